>>> src/rrb_pkg.sv
// shared codes and types of the reverse reachability search unit
package rrb_pkg;

  localparam int FIELD_W = 6;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [2:0] ST_DONE  = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_REACH = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  localparam logic [2:0] CFG_ADDR_VC = 3'd0;
  localparam logic [6:0] VC_RESET    = 7'd64;

  typedef struct packed {
    logic [2:0]         status;
    logic [FIELD_W-1:0] vertex;
    logic               last;
  } res_t;

endpackage

>>> src/rrb_if.sv
// valid/ready channel interfaces for command and result beats
interface rrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] from_vertex;
  logic [5:0] to_vertex;

  modport source (output valid, output operation, output from_vertex, output to_vertex,
                  input ready);
  modport sink (input valid, input operation, input from_vertex, input to_vertex,
                output ready);
endinterface

interface rrb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] vertex;
  logic       last;

  modport source (output valid, output status, output vertex, output last, input ready);
  modport sink (input valid, input status, input vertex, input last, output ready);
endinterface

>>> src/rrb_out_q.sv
// two-entry result queue driving the result channel
module rrb_out_q
  import rrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  res_t       push_data,
  output logic       full,
  rrb_out_if.source  out_ch
);

  logic [1:0] cnt_r, cnt_nxt;
  res_t       slot0_r, slot1_r;
  logic       pop;

  assign pop          = out_ch.valid && out_ch.ready;
  assign full         = (cnt_r == 2'd2);
  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.status = slot0_r.status;
  assign out_ch.vertex = slot0_r.vertex;
  assign out_ch.last   = slot0_r.last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_valid && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // head always sits in slot0
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0_r <= (push_valid && cnt_r == 2'd1) ? push_data : slot1_r;
      if (push_valid && cnt_r == 2'd2) begin
        slot1_r <= push_data;
      end
    end else if (push_valid) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= push_data;
      end else begin
        slot1_r <= push_data;
      end
    end
  end

endmodule

>>> src/reverse_reachability_bfs_unit.sv
// top level of the reverse reachability search unit: edge store, search sequencer, apb register
//
//  channel   dir   handshake              beat contents
//  in_ch     in    valid/ready            operation, from_vertex, to_vertex
//  out_ch    out   valid/ready            status, vertex, last
//  apb       in    psel/penable, pready   vertex_count at byte address 0
//
// clear and add-edge results land in a two-entry output queue
// a query restarts a breadth-first walk from each source vertex; every dequeued vertex
// sweeps the edge memory once through its single read port
// rst_n is synchronous; the edge store holds no reset, only its fill count is cleared
// a full output queue stalls the sequencer where it has a result to push, and holds in_ch.ready low
module reverse_reachability_bfs_unit
  import rrb_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  rrb_in_if.sink      in_ch,
  rrb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // vertices actually addressable: the vertex fields are six bits wide
  localparam int VMAX = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int VW   = $clog2(VMAX);
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [6:0]      vc_r;
  logic [CW-1:0]   edges_r, edges_nxt;
  logic [VMAX-1:0] visited_r, visited_nxt;
  logic [VW-1:0]   k_r, k_nxt;
  logic [VW:0]     head_r, head_nxt;
  logic [VW:0]     tail_r, tail_nxt;
  logic [CW-1:0]   issue_r, issue_nxt;
  logic            dv_r, dv_nxt;
  logic [5:0]      to_r, to_nxt;
  logic [VW-1:0]   pend_r, pend_nxt;
  logic            has_pend_r, has_pend_nxt;

  // edge memory: {source, target}
  logic [11:0]     edge_mem [MAX_EDGES];
  logic [11:0]     e_rd_r;
  logic            e_we, e_re;
  logic [EW-1:0]   e_raddr;

  // frontier queue memory
  logic [VW-1:0]   q_mem [VMAX];
  logic [VW-1:0]   q_rd_r;
  logic            q_we, q_re;
  logic [VW-1:0]   q_waddr, q_raddr, q_wdata;

  logic [6:0]      cnt_eff;
  logic            in_acc;
  logic            push_valid;
  res_t            push_data;
  logic            q_full;
  logic            k_last;
  logic [5:0]      e_src, e_tgt;
  logic            cfg_wr;

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == CFG_ADDR_VC);
  assign prdata = (paddr == CFG_ADDR_VC) ? {25'd0, vc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else if (cfg_wr) begin
      vc_r <= pwdata[6:0];
    end
  end

  assign cnt_eff     = (vc_r > 7'(VMAX)) ? 7'(VMAX) : vc_r;
  assign in_ch.ready = (state_r == S_IDLE) && !q_full;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign k_last      = ((7'(k_r) + 7'd1) == cnt_eff);
  assign e_src       = e_rd_r[11:6];
  assign e_tgt       = e_rd_r[5:0];

  always_comb begin
    state_nxt    = state_r;
    edges_nxt    = edges_r;
    visited_nxt  = visited_r;
    k_nxt        = k_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    issue_nxt    = issue_r;
    dv_nxt       = dv_r;
    to_nxt       = to_r;
    pend_nxt     = pend_r;
    has_pend_nxt = has_pend_r;
    e_we         = 1'b0;
    e_re         = 1'b0;
    e_raddr      = issue_r[EW-1:0];
    q_we         = 1'b0;
    q_re         = 1'b0;
    q_waddr      = tail_r[VW-1:0];
    q_wdata      = k_r;
    q_raddr      = head_r[VW-1:0];
    push_valid   = 1'b0;
    push_data    = '{status: ST_DONE, vertex: '0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.operation)
            OP_CLEAR: begin
              edges_nxt  = '0;
              push_valid = 1'b1;
            end
            OP_ADD: begin
              push_valid = 1'b1;
              if ({1'b0, in_ch.from_vertex} >= cnt_eff ||
                  {1'b0, in_ch.to_vertex} >= cnt_eff) begin
                push_data.status = ST_RANGE;
              end else if (edges_r == CW'(MAX_EDGES)) begin
                push_data.status = ST_FULL;
              end else begin
                e_we      = 1'b1;
                edges_nxt = edges_r + CW'(1);
              end
            end
            OP_QUERY: begin
              if ({1'b0, in_ch.to_vertex} >= cnt_eff) begin
                push_valid       = 1'b1;
                push_data.status = ST_RANGE;
              end else begin
                to_nxt       = in_ch.to_vertex;
                k_nxt        = '0;
                has_pend_nxt = 1'b0;
                state_nxt    = S_INIT;
              end
            end
            default: begin
              // unused operation code gives no result
            end
          endcase
        end
      end

      S_INIT: begin
        if (6'(k_r) == to_r) begin
          if (k_last) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt = k_r + VW'(1);
          end
        end else begin
          visited_nxt      = '0;
          visited_nxt[k_r] = 1'b1;
          q_we             = 1'b1;
          q_waddr          = '0;
          q_wdata          = k_r;
          head_nxt         = '0;
          tail_nxt         = (VW+1)'(1);
          state_nxt        = S_POP;
        end
      end

      S_POP: begin
        if (head_r == tail_r) begin
          state_nxt = S_CHECK;
        end else begin
          q_re      = 1'b1;
          head_nxt  = head_r + (VW+1)'(1);
          issue_nxt = '0;
          dv_nxt    = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // each edge read is compared in the cycle after it is issued
        dv_nxt = 1'b0;
        if (issue_r < edges_r) begin
          e_re      = 1'b1;
          issue_nxt = issue_r + CW'(1);
          dv_nxt    = 1'b1;
        end
        if (dv_r && e_src == 6'(q_rd_r) && {1'b0, e_tgt} < cnt_eff &&
            !visited_r[e_tgt[VW-1:0]]) begin
          visited_nxt[e_tgt[VW-1:0]] = 1'b1;
          q_we     = 1'b1;
          q_wdata  = e_tgt[VW-1:0];
          tail_nxt = tail_r + (VW+1)'(1);
        end
        if (!(issue_r < edges_r) && !dv_r) begin
          state_nxt = S_POP;
        end
      end

      S_CHECK: begin
        // a reaching vertex is held back until we know whether it is the last one
        if (!(visited_r[to_r[VW-1:0]] && has_pend_r && q_full)) begin
          if (visited_r[to_r[VW-1:0]]) begin
            if (has_pend_r) begin
              push_valid = 1'b1;
              push_data  = '{status: ST_REACH, vertex: 6'(pend_r), last: 1'b0};
            end
            pend_nxt     = k_r;
            has_pend_nxt = 1'b1;
          end
          if (k_last) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt     = k_r + VW'(1);
            state_nxt = S_INIT;
          end
        end
      end

      S_FIN: begin
        if (!q_full) begin
          push_valid = 1'b1;
          if (has_pend_r) begin
            push_data = '{status: ST_REACH, vertex: 6'(pend_r), last: 1'b1};
          end else begin
            push_data = '{status: ST_NONE, vertex: '0, last: 1'b1};
          end
          visited_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      edges_r    <= '0;
      visited_r  <= '0;
      has_pend_r <= 1'b0;
      dv_r       <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      edges_r    <= edges_nxt;
      visited_r  <= visited_nxt;
      has_pend_r <= has_pend_nxt;
      dv_r       <= dv_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    issue_r <= issue_nxt;
    to_r    <= to_nxt;
    pend_r  <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[edges_r[EW-1:0]] <= {in_ch.from_vertex, in_ch.to_vertex};
    end
    if (e_re) begin
      e_rd_r <= edge_mem[e_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_r <= q_mem[q_raddr];
    end
  end

  rrb_out_q u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= CW'(MAX_EDGES))
    else $error("edge fill count beyond store depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !q_full)
    else $error("result pushed into full output queue");

  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_POP) |-> (7'(tail_r) <= cnt_eff))
    else $error("frontier queue grew past vertex count");

  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (head_r <= tail_r && head_r != '0))
    else $error("frontier head passed tail");
`endif

endmodule
